// ----- rtl/text_page_break_finder_unit_assert.svh -----
// Assertion macros for the text page break finder
`ifndef TEXT_PAGE_BREAK_FINDER_UNIT_ASSERT_SVH
`define TEXT_PAGE_BREAK_FINDER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define TPBF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tpbf assertion failed");
`define TPBF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tpbf assertion failed");
`else
`define TPBF_ASSERT(lbl, prop)
`define TPBF_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- rtl/tpbf_pkg.sv -----
// Shared types and constants of the text page break finder
package tpbf_pkg;

  localparam logic [7:0] ESC_CODE   = 8'h1B;
  localparam logic [7:0] ESC_END    = 8'h6D;
  localparam logic [7:0] TAB_CODE   = 8'h09;
  localparam logic [7:0] CR_CODE    = 8'h0D;
  localparam logic [7:0] LF_CODE    = 8'h0A;
  localparam logic [3:0] ESC_MAX    = 4'd9;
  localparam logic [7:0] LINE_MAX   = 8'hFF;
  localparam logic [15:0] PAGES_MAX = 16'hFFFF;

  localparam logic [7:0] DEFAULT_WIDTH  = 8'd80;
  localparam logic [7:0] DEFAULT_LENGTH = 8'd22;
  localparam logic [7:0] WIDTH_MIN      = 8'd40;
  localparam logic [7:0] WIDTH_MAX      = 8'd250;
  localparam logic [7:0] LENGTH_MIN     = 8'd5;

  localparam logic [7:0] RESET_SCREEN_WIDTH = 8'd80;
  localparam logic [7:0] RESET_PAGE_LENGTH  = 8'd22;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH = 2'd0,
    REG_PAGE_LENGTH  = 2'd1,
    REG_COMPACT_MODE = 2'd2
  } cfg_reg_t;

  // effective settings seen by the step logic
  typedef struct packed {
    logic [7:0] width;
    logic [7:0] limit;
  } cfg_t;

endpackage

// ----- rtl/tpbf_cfg.sv -----
// Configuration registers and derived page geometry
module tpbf_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  output tpbf_pkg::cfg_t   cfg
);
  import tpbf_pkg::*;

  logic [7:0] screen_width;
  logic [7:0] page_rows;
  logic       compact_mode;
  logic [7:0] width_eff;
  logic [7:0] length_eff;
  cfg_t       cfg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= RESET_SCREEN_WIDTH;
      page_rows    <= RESET_PAGE_LENGTH;
      compact_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH: screen_width <= cfg_data;
        REG_PAGE_LENGTH:  page_rows    <= cfg_data;
        REG_COMPACT_MODE: compact_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // out-of-range settings fall back to defaults
  always_comb begin
    width_eff  = (screen_width >= WIDTH_MIN && screen_width <= WIDTH_MAX) ?
                 screen_width : DEFAULT_WIDTH;
    length_eff = (page_rows < LENGTH_MIN) ? DEFAULT_LENGTH : page_rows;
    cfg_next.width = width_eff;
    cfg_next.limit = length_eff - (compact_mode ? 8'd1 : 8'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width <= RESET_SCREEN_WIDTH;
      cfg.limit <= RESET_PAGE_LENGTH - 8'd2;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ----- rtl/tpbf_core.sv -----
// Input register, per-byte step logic with text state, result register
`include "text_page_break_finder_unit_assert.svh"
module tpbf_core #(
  parameter int POSITION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  tpbf_pkg::cfg_t      cfg,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,
  output logic                m_tlast
);
  import tpbf_pkg::*;

  // input stage
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_end;

  // text state
  logic [7:0]               column, column_next;
  logic [7:0]               line_count, line_count_next;
  logic                     escape_active, escape_active_next;
  logic [3:0]               escape_count, escape_count_next;
  logic                     tab_pending, tab_pending_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [15:0]              pages_so_far, pages_so_far_next;

  // result stage
  logic        out_valid;
  logic [15:0] out_start, out_start_next;
  logic [15:0] out_pages, out_pages_next;
  logic        out_last;

  logic                      examined;
  logic                      page_break;
  logic                      has_result;
  logic                      out_free;
  logic                      process;
  logic                      load_out;
  logic [3:0]                esc_cnt_inc;
  logic [15:0]               pages_inc;
  logic [POSITION_BITS+15:0] pos_ext;
  logic [7:0]                col;
  logic [7:0]                ln;
  logic                      text_cleared;

  assign examined   = !escape_active && (!tab_pending || in_char == TAB_CODE);
  assign page_break = examined && (line_count > cfg.limit);
  assign has_result = in_end || page_break;
  assign out_free   = !out_valid || m_tready;
  assign process    = in_valid && (!has_result || out_free);
  assign load_out   = process && has_result;
  assign s_tready   = !in_valid || process;

  assign esc_cnt_inc = escape_count + 4'd1;
  assign pages_inc   = (pages_so_far == PAGES_MAX) ? pages_so_far : pages_so_far + 16'd1;
  assign pos_ext     = {16'd0, byte_position};

  always_comb begin
    column_next        = column;
    line_count_next    = line_count;
    escape_active_next = escape_active;
    escape_count_next  = escape_count;
    tab_pending_next   = tab_pending;
    byte_position_next = byte_position + POSITION_BITS'(1);
    pages_so_far_next  = pages_so_far;
    out_start_next     = pos_ext[15:0];
    out_pages_next     = pages_inc;
    col                = column;
    ln                 = line_count;

    if (in_end) begin
      // report total and clear
      out_pages_next     = pages_so_far;
      column_next        = 8'd1;
      line_count_next    = 8'd1;
      escape_active_next = 1'b0;
      escape_count_next  = 4'd0;
      tab_pending_next   = 1'b0;
      byte_position_next = '0;
      pages_so_far_next  = 16'd1;
    end else if (escape_active) begin
      escape_count_next = esc_cnt_inc;
      if (in_char == ESC_END || esc_cnt_inc >= ESC_MAX) begin
        escape_active_next = 1'b0;
        escape_count_next  = 4'd0;
      end
    end else if (tab_pending && in_char != TAB_CODE) begin
      tab_pending_next = 1'b0;
    end else begin
      tab_pending_next = 1'b0;
      if (page_break) begin
        pages_so_far_next = pages_inc;
        col = 8'd1;
        ln  = 8'd1;
      end
      case (in_char)
        ESC_CODE: begin
          escape_active_next = 1'b1;
          escape_count_next  = 4'd0;
        end
        TAB_CODE: tab_pending_next = 1'b1;
        CR_CODE:  col = 8'd1;
        LF_CODE: begin
          if (ln < LINE_MAX) ln = ln + 8'd1;
        end
        default: begin
          if (col > cfg.width) begin
            col = 8'd1;
            if (ln < LINE_MAX) ln = ln + 8'd1;
          end else begin
            col = col + 8'd1;
          end
        end
      endcase
      column_next     = col;
      line_count_next = ln;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      column        <= 8'd1;
      line_count    <= 8'd1;
      escape_active <= 1'b0;
      escape_count  <= 4'd0;
      tab_pending   <= 1'b0;
      byte_position <= '0;
      pages_so_far  <= 16'd1;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (process) begin
        column        <= column_next;
        line_count    <= line_count_next;
        escape_active <= escape_active_next;
        escape_count  <= escape_count_next;
        tab_pending   <= tab_pending_next;
        byte_position <= byte_position_next;
        pages_so_far  <= pages_so_far_next;
      end
      if (load_out) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_end  <= s_tlast;
    end
    if (load_out) begin
      out_start <= out_start_next;
      out_pages <= out_pages_next;
      out_last  <= in_end;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_pages, out_start};
  assign m_tlast  = out_last;

  // text state back at its reset values
  assign text_cleared = pages_so_far == 16'd1 && byte_position == '0 &&
                        !escape_active && !tab_pending;

  `TPBF_ASSERT(a_no_result_overwrite, !(out_valid && !m_tready && load_out))
  `TPBF_ASSERT(a_esc_count_idle, escape_active || escape_count == 4'd0)
  `TPBF_ASSERT(a_pages_nonzero, pages_so_far != 16'd0)
  `TPBF_ASSERT_NEXT(a_end_clears, process && in_end, text_cleared)
  `TPBF_ASSERT_NEXT(a_break_result, load_out && !in_end, !out_last && out_pages >= 16'd2)

endmodule

// ----- rtl/text_page_break_finder_unit.sv -----
// Top level of the text page break finder
//
//  channel   dir  signals                          carries
//  s_*       in   s_tvalid s_tready s_tdata s_tlast text bytes, end-of-text marker
//  m_*       out  m_tvalid m_tready m_tdata m_tlast page starts and final page count
//  cfg_*     in   cfg_we cfg_index cfg_data          screen width, page length, compact
//
// One byte per cycle, unless a result byte waits on a held result: each request
// is held in the input register, the step logic updates column/line/skip state
// and, on a page break or end of text, loads the result register.
// A byte that makes no result moves on even while the result register is
// stalled; a byte that makes a result waits there until the held result
// is taken. Reset (rst, synchronous) empties both stages and restores the
// text state and the registers to 80 columns, 22 lines, non-compact.
// Derived width/limit are registered in the cycle after a config write.
module text_page_break_finder_unit #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] char_code
  input  logic        s_tlast,    // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [15:0] page_start, [31:16] page_number
  output logic        m_tlast,    // text_done
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tpbf_pkg::*;

  cfg_t cfg;

  // registered, range-checked page geometry
  tpbf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // byte stream stepping and result register
  tpbf_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- tb/sv/page_break_checker.sv -----
`timescale 1ns / 100ps
// Page break checker: follows the text and page channels, predicts and compares results
module page_break_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] char_code
  input  logic        s_tlast,    // end_of_text
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,    // [15:0] page_start, [31:16] page_number
  input  logic        m_tlast,    // text_done
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  import tpbf_pkg::*;

  typedef struct packed {
    logic [15:0] page_start;
    logic [15:0] page_number;
    logic        text_done;
  } page_mark_t;

  page_mark_t page_marks[$];

  // register copies
  logic [7:0]  width_reg;
  logic [7:0]  length_reg;
  logic        compact_reg;

  // text state
  logic [7:0]  column;
  logic [7:0]  line_no;
  logic        in_escape;
  logic [3:0]  escape_len;
  logic        tab_skip;
  logic [15:0] text_pos;
  logic [15:0] page_count;

  int errors = 0;

  task automatic clear_text();
    column     = 8'd1;
    line_no    = 8'd1;
    in_escape  = 1'b0;
    escape_len = 4'd0;
    tab_skip   = 1'b0;
    text_pos   = 16'd0;
    page_count = 16'd1;
  endtask

  task automatic find_page_break(input logic [7:0] code, input logic eot);
    logic [7:0]  eff_width;
    logic [7:0]  eff_length;
    logic [7:0]  eff_limit;
    logic [15:0] here;
    logic        examine;
    page_mark_t  mark;
    if (eot) begin
      mark = '{page_start: text_pos, page_number: page_count, text_done: 1'b1};
      page_marks.push_back(mark);
      clear_text();
    end else begin
      here = text_pos;
      text_pos = text_pos + 16'd1;
      examine = 1'b0;
      if (in_escape) begin
        escape_len = escape_len + 4'd1;
        if (code == ESC_END || escape_len >= ESC_MAX) begin
          in_escape  = 1'b0;
          escape_len = 4'd0;
        end
      end else if (tab_skip) begin
        tab_skip = 1'b0;
        examine  = (code == TAB_CODE);
      end else begin
        examine = 1'b1;
      end
      if (examine) begin
        eff_width  = (width_reg >= WIDTH_MIN && width_reg <= WIDTH_MAX) ? width_reg
                                                                         : DEFAULT_WIDTH;
        eff_length = (length_reg < LENGTH_MIN) ? DEFAULT_LENGTH : length_reg;
        eff_limit  = eff_length - (compact_reg ? 8'd1 : 8'd2);
        if (line_no > eff_limit) begin
          if (page_count != PAGES_MAX) page_count = page_count + 16'd1;
          mark = '{page_start: here, page_number: page_count, text_done: 1'b0};
          page_marks.push_back(mark);
          column  = 8'd1;
          line_no = 8'd1;
        end
        if (code == ESC_CODE) begin
          in_escape  = 1'b1;
          escape_len = 4'd0;
        end else if (code == TAB_CODE) begin
          tab_skip = 1'b1;
        end else if (code == CR_CODE) begin
          column = 8'd1;
        end else if (code == LF_CODE) begin
          if (line_no != LINE_MAX) line_no = line_no + 8'd1;
        end else if (column > eff_width) begin
          column = 8'd1;
          if (line_no != LINE_MAX) line_no = line_no + 8'd1;
        end else begin
          column = column + 8'd1;
        end
      end
    end
  endtask

  task automatic check_page_mark(input logic [31:0] data, input logic last);
    page_mark_t mark;
    if (page_marks.size() == 0) begin
      errors++;
      $error("unexpected result: page_start %0d page_number %0d text_done %0b",
             data[15:0], data[31:16], last);
    end else begin
      mark = page_marks.pop_front();
      if (data[15:0] !== mark.page_start) begin
        errors++;
        $error("page_start: expected %0d, got %0d", mark.page_start, data[15:0]);
      end
      if (data[31:16] !== mark.page_number) begin
        errors++;
        $error("page_number: expected %0d, got %0d", mark.page_number, data[31:16]);
      end
      if (last !== mark.text_done) begin
        errors++;
        $error("text_done: expected %0b, got %0b", mark.text_done, last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg   = RESET_SCREEN_WIDTH;
      length_reg  = RESET_PAGE_LENGTH;
      compact_reg = 1'b0;
      clear_text();
      page_marks.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SCREEN_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_PAGE_LENGTH) length_reg = cfg_data;
        else if (cfg_index == REG_COMPACT_MODE) compact_reg = cfg_data[0];
      end
      // new request first: a result can never leave in the edge its byte enters
      if (s_tvalid && s_tready) find_page_break(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_page_mark(m_tdata, m_tlast);
    end
    fail_count <= errors;
    pending    <= page_marks.size();
  end

endmodule

// ----- tb/sv/text_page_break_finder_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench top: drives text and settings into the page break finder and gives the verdict
module text_page_break_finder_unit_tb;
  import tpbf_pkg::*;

  localparam int HOLD_CYCLES    = 400;   // one long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request moving on either side
  localparam int SETTLE_CYCLES  = 8;     // pipeline is two deep, plus derived settings
  localparam int RANDOM_ITEMS   = 1250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;        // [7:0] char_code
  logic        s_tlast = 1'b0;        // end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;               // [15:0] page_start, [31:16] page_number
  logic        m_tlast;               // text_done
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_SCREEN_WIDTH;
  logic [7:0]  cfg_data = 8'd0;

  int fail_count;
  int pending;

  // sender pacing and bookkeeping
  int burst_left  = 0;
  bit no_gaps     = 1'b0;
  int items_sent  = 0;
  bit hold_req    = 1'b0;   // set by stimulus, cleared by the receiver when done
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  text_page_break_finder_unit #(.POSITION_BITS(16)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  page_break_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Watchdog: any request moving on either channel rearms it.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("text_page_break_finder_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: segments of its own stall pattern, plus one long hold-off on request.
  initial begin : receiver
    int seg_left;
    int mode;
    seg_left = 0;
    mode     = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // block fills: result register, then input register, then s_tready drops
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 120);
      end else begin
        seg_left--;
        case (mode)
          0:       m_tready <= 1'b1;                          // no stalls
          1:       m_tready <= 1'($urandom_range(0, 1));      // coin flip
          2:       m_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
          default: m_tready <= ($urandom_range(0, 3) != 0);   // light stalls
        endcase
      end
      @(posedge clk);
    end
  end

  // One text request; bursts of random length with random gaps in between.
  task automatic send_item(input logic [7:0] code, input logic eot);
    int gap;
    if (burst_left <= 0) begin
      if (no_gaps) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(5, 20);
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Stop sending, let every expected result drain, then let the pipe settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All three registers, back to back; derived width/limit are registered in the cycle after.
  task automatic set_config(input logic [7:0] cols, input logic [7:0] rows,
                            input logic compact);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= REG_PAGE_LENGTH;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= REG_COMPACT_MODE;
    cfg_data  <= {7'd0, compact};
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  // One piece of text: mostly well-formed lines, color sequences and tabs,
  // with some raw bytes and cut-off sequences mixed in.
  task automatic send_token();
    int kind;
    int n;
    kind = $urandom_range(0, 15);
    case (kind)
      0, 1, 2: begin
        n = $urandom_range(1, 30);
        repeat (n) send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      end
      3: begin
        // long line: up to 260 bytes, enough to wrap past any legal width
        n = $urandom_range(40, 260);
        repeat (n) send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      end
      4, 5, 6: send_item(LF_CODE, 1'b0);
      7: begin
        send_item(CR_CODE, 1'b0);
        send_item(LF_CODE, 1'b0);
      end
      8: send_item(CR_CODE, 1'b0);
      9: begin
        // well-formed color sequence, closed by 'm' inside the skip window
        send_item(ESC_CODE, 1'b0);
        send_item("[", 1'b0);
        n = $urandom_range(0, 6);
        repeat (n)
          send_item(8'(($urandom_range(0, 3) == 0) ? 32'h3B : $urandom_range(8'h30, 8'h39)),
                    1'b0);
        send_item(ESC_END, 1'b0);
      end
      10: begin
        // unterminated skip: runs out after nine bytes, or gets cut by end of text
        send_item(ESC_CODE, 1'b0);
        n = $urandom_range(1, 12);
        repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      11: begin
        send_item(TAB_CODE, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      12: begin
        send_item(TAB_CODE, 1'b0);
        send_item(TAB_CODE, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      13: send_item(8'($urandom_range(0, 255)), 1'b0);
      14: begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(LF_CODE, 1'b0);
      end
      default: begin
        send_item(ESC_CODE, 1'b0);
        send_item(ESC_END, 1'b0);
      end
    endcase
  endtask

  // Opening text under reset settings: byte extremes, a color skip ended by 'm',
  // tab skips, tab after tab, CR/LF, then an empty text and a skip cut by end.
  logic [8:0] opening_text [23] = '{
    {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, ESC_CODE}, {1'b0, 8'h5B}, {1'b0, 8'h31},
    {1'b0, ESC_END}, {1'b0, 8'h41}, {1'b0, TAB_CODE}, {1'b0, 8'h78}, {1'b0, TAB_CODE},
    {1'b0, TAB_CODE}, {1'b0, 8'h79}, {1'b0, CR_CODE}, {1'b0, LF_CODE}, {1'b0, LF_CODE},
    {1'b0, LF_CODE}, {1'b0, LF_CODE}, {1'b0, 8'h7A}, {1'b1, 8'h00}, {1'b1, 8'hFF},
    {1'b0, ESC_CODE}, {1'b0, 8'h71}, {1'b1, 8'h00}
  };

  initial begin : stimulus
    int phase;
    int tokens;
    int start_items;
    logic [7:0] cols;
    logic [7:0] rows;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_text[i]) send_item(opening_text[i][7:0], opening_text[i][8]);
    wait_idle();

    // Shortest page (limit 3): every third LF breaks. The receiver holds off
    // meanwhile while the sender keeps offering, so results back up and the
    // input stalls.
    set_config(8'd80, 8'd5, 1'b0);
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    repeat (60) send_item(LF_CODE, 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    no_gaps  = 1'b0;
    wait_idle();

    // Random texts, settings swept over their extremes between texts.
    start_items = items_sent;
    phase = 0;
    while (items_sent < start_items + RANDOM_ITEMS) begin
      case (phase % 8)
        0:       cols = 8'd0;
        1:       cols = 8'd39;
        2:       cols = 8'd40;
        3:       cols = 8'd250;
        4:       cols = 8'd251;
        5:       cols = 8'd255;
        6:       cols = 8'd60;
        default: cols = 8'($urandom_range(0, 255));
      endcase
      case (phase % 7)
        0:       rows = 8'd0;
        1:       rows = 8'd4;
        2:       rows = 8'd5;
        3:       rows = 8'd255;
        4:       rows = 8'd6;
        5:       rows = 8'd8;
        default: rows = 8'($urandom_range(5, 12));
      endcase
      set_config(cols, rows, 1'((phase / 2) % 2));
      tokens = $urandom_range(0, 20);
      repeat (tokens) send_token();
      send_item(8'($urandom_range(0, 255)), 1'b1);
      wait_idle();
      phase++;
    end

    if (fail_count == 0 && pending == 0) begin
      $display("text_page_break_finder_unit_tb OK");
    end else begin
      $display("text_page_break_finder_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
